@@ design/oqrk_pkg.sv @@
package oqrk_pkg;

  // Field widths
  localparam int OP_W     = 2;
  localparam int KEY_W    = 32;
  localparam int STATUS_W = 2;

  // Packed stream widths, filled up to whole bytes
  localparam int S_FIELDS_W = OP_W + KEY_W;
  localparam int M_FIELDS_W = STATUS_W + KEY_W;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  typedef logic [OP_W-1:0]     opcode_t;
  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Operation codes
  localparam opcode_t OP_PUSH   = 2'd0;
  localparam opcode_t OP_REMOVE = 2'd1;
  localparam opcode_t OP_READ   = 2'd2;

  // Result status codes
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NOT_FOUND = 2'd1;
  localparam status_t ST_FULL      = 2'd2;
  localparam status_t ST_EMPTY     = 2'd3;

endpackage

@@ design/oqrk_ram.sv @@
module oqrk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, held while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/ordered_queue_remove_by_key.sv @@
// Channel  Dir  tdata (low bit first)           tuser  tlast
// s_*      in   opcode[1:0], key[33:2], zeros   -      -
// m_*      out  status[1:0], entry[33:2], zeros -      last result of the item
//
// Push: accepted and written to the tail in the same cycle, result from the RESULT state.
// Remove: one memory read per cycle over the live entries;
//   entries behind the match are written back one place toward the head as
//   they stream past the read port.
// Readout: one result per cycle while m_tready holds high, set by the single
//   read port of the entry memory; a stalled output holds the read data.
// Reset clears the entry count and the handshake state; the entry memory
//   needs no clearing pass.
module ordered_queue_remove_by_key #(
  parameter int DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [oqrk_pkg::S_TDATA_W-1:0] s_tdata,  // opcode, key, zero fill
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [oqrk_pkg::M_TDATA_W-1:0] m_tdata,  // status, entry, zero fill
  output logic                           m_tlast
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    DUMP,
    RESULT
  } state_t;

  state_t                state;
  logic [CW-1:0]         cnt;
  logic [CW-1:0]         rd_ptr;
  logic                  data_valid;
  logic [AW-1:0]         data_idx;
  logic                  found;
  oqrk_pkg::key_t        key_q;
  oqrk_pkg::status_t     res_status;
  oqrk_pkg::status_t     m_status;
  oqrk_pkg::key_t        m_entry;

  logic                  ram_wr_en;
  logic [AW-1:0]         ram_wr_addr;
  oqrk_pkg::key_t        ram_wr_data;
  logic                  ram_rd_en;
  logic [AW-1:0]         ram_rd_addr;
  oqrk_pkg::key_t        ram_rd_data;

  oqrk_pkg::opcode_t     s_op;
  oqrk_pkg::key_t        s_key;
  logic                  in_acc;
  logic                  out_free;
  logic                  full;
  logic                  rd_more;
  logic                  last_idx;
  logic                  match;
  logic                  consume;
  logic                  out_load;

  // Unpack input beat
  assign s_op  = s_tdata[oqrk_pkg::OP_W-1:0];
  assign s_key = s_tdata[oqrk_pkg::S_FIELDS_W-1:oqrk_pkg::OP_W];

  assign s_tready = (state == IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign full     = (cnt == CW'(DEPTH));
  assign rd_more  = (rd_ptr < cnt);
  assign last_idx = (CW'(data_idx) == cnt - CW'(1));
  assign match    = (ram_rd_data == key_q);
  assign consume  = (state == DUMP) && data_valid && out_free;
  assign out_load = consume || ((state == RESULT) && out_free);

  // Read port: stream in scan, pace with the output in readout
  assign ram_rd_addr = rd_ptr[AW-1:0];
  always_comb begin
    case (state)
      SCAN:    ram_rd_en = rd_more;
      DUMP:    ram_rd_en = rd_more && (!data_valid || out_free);
      default: ram_rd_en = 1'b0;
    endcase
  end

  // Write port: append on push, close the gap behind a match
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = cnt[AW-1:0];
    ram_wr_data = s_key;
    if (in_acc && s_op == oqrk_pkg::OP_PUSH && !full) begin
      ram_wr_en = 1'b1;
    end else if (state == SCAN && data_valid && found) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = data_idx - AW'(1);
      ram_wr_data = ram_rd_data;
    end
  end

  oqrk_ram #(
    .WIDTH (oqrk_pkg::KEY_W),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      cnt        <= '0;
      data_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_acc) begin
            key_q      <= s_key;
            rd_ptr     <= '0;
            data_valid <= 1'b0;
            found      <= 1'b0;
            case (s_op)
              oqrk_pkg::OP_PUSH: begin
                if (full) begin
                  res_status <= oqrk_pkg::ST_FULL;
                end else begin
                  cnt        <= cnt + CW'(1);
                  res_status <= oqrk_pkg::ST_OK;
                end
                state <= RESULT;
              end
              oqrk_pkg::OP_REMOVE: begin
                if (cnt == '0) begin
                  res_status <= oqrk_pkg::ST_NOT_FOUND;
                  state      <= RESULT;
                end else begin
                  state <= SCAN;
                end
              end
              oqrk_pkg::OP_READ: begin
                if (cnt == '0) begin
                  res_status <= oqrk_pkg::ST_EMPTY;
                  state      <= RESULT;
                end else begin
                  state <= DUMP;
                end
              end
              default: ;
            endcase
          end
        end
        SCAN: begin
          data_valid <= ram_rd_en;
          if (ram_rd_en) begin
            rd_ptr   <= rd_ptr + CW'(1);
            data_idx <= ram_rd_addr;
          end
          if (data_valid) begin
            if (!found && match) begin
              found <= 1'b1;
            end
            if (last_idx) begin
              state <= RESULT;
              if (found || match) begin
                cnt        <= cnt - CW'(1);
                res_status <= oqrk_pkg::ST_OK;
              end else begin
                res_status <= oqrk_pkg::ST_NOT_FOUND;
              end
            end
          end
        end
        DUMP: begin
          data_valid <= ram_rd_en || (data_valid && !out_free);
          if (ram_rd_en) begin
            rd_ptr   <= rd_ptr + CW'(1);
            data_idx <= ram_rd_addr;
          end
          if (consume) begin
            m_status <= oqrk_pkg::ST_OK;
            m_entry  <= ram_rd_data;
            m_tlast  <= last_idx;
            if (last_idx) begin
              state <= IDLE;
            end
          end
        end
        RESULT: begin
          if (out_free) begin
            m_status <= res_status;
            m_entry  <= '0;
            m_tlast  <= 1'b1;
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // Pack output beat
  assign m_tdata = {{(oqrk_pkg::M_TDATA_W - oqrk_pkg::M_FIELDS_W){1'b0}}, m_entry, m_status};

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("entry count above depth");

  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && cnt != $past(cnt)) |->
      (cnt == $past(cnt) + CW'(1) || cnt == $past(cnt) - CW'(1)))
    else $error("entry count moved by more than one");

  a_dump_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == DUMP) |-> !ram_wr_en)
    else $error("entry memory written during readout");

  a_idx_live: assert property (@(posedge clk) disable iff (rst)
    (data_valid && (state == SCAN || state == DUMP)) |-> (CW'(data_idx) < cnt))
    else $error("read data index beyond live entries");

endmodule

@@ bench/oqrk_checker.sv @@
module oqrk_checker
  import oqrk_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,  // opcode, key, zero fill
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [M_TDATA_W-1:0] m_tdata,  // status, entry, zero fill
  input  logic                 m_tlast,
  output int                   fail_count,
  output int                   pending
);

  typedef struct packed {
    status_t status;
    key_t    entry;
    logic    last;
  } result_beat_t;

  // Mirror of the queue, head at index 0
  key_t         queue_image[$];
  result_beat_t expected_beats[$];
  int           failures = 0;

  task automatic report_mismatch(string what, logic [M_TDATA_W-1:0] got,
                                 logic [M_TDATA_W-1:0] want);
    failures++;
    $display("%0t: mismatch on %s, got %h, want %h", $time, what, got, want);
  endtask

  // Apply one accepted item to the mirror and queue up the beats it causes
  task automatic predict_item(opcode_t op, key_t key);
    result_beat_t beat;
    int           hit;
    beat = '{status: ST_OK, entry: '0, last: 1'b1};
    hit  = -1;
    case (op)
      OP_PUSH: begin
        if (queue_image.size() >= DEPTH) beat.status = ST_FULL;
        else queue_image.push_back(key);
        expected_beats.push_back(beat);
      end
      OP_REMOVE: begin
        // only the occurrence nearest the head goes
        foreach (queue_image[i]) begin
          if (hit < 0 && queue_image[i] == key) hit = i;
        end
        if (hit < 0) beat.status = ST_NOT_FOUND;
        else queue_image.delete(hit);
        expected_beats.push_back(beat);
      end
      OP_READ: begin
        if (queue_image.size() == 0) begin
          beat.status = ST_EMPTY;
          expected_beats.push_back(beat);
        end else begin
          foreach (queue_image[i]) begin
            beat.entry = queue_image[i];
            beat.last  = (i == queue_image.size() - 1);
            expected_beats.push_back(beat);
          end
        end
      end
      default: ;  // unused code: no state change, no beats
    endcase
  endtask

  // Compare one output beat with the oldest expectation
  task automatic check_beat(logic [M_TDATA_W-1:0] data, logic last);
    result_beat_t want;
    if (expected_beats.size() == 0) begin
      report_mismatch("unexpected beat", data, '0);
      return;
    end
    want = expected_beats.pop_front();
    if (data[STATUS_W-1:0] !== want.status)
      report_mismatch("status", M_TDATA_W'(data[STATUS_W-1:0]), M_TDATA_W'(want.status));
    if (data[STATUS_W +: KEY_W] !== want.entry)
      report_mismatch("entry", M_TDATA_W'(data[STATUS_W +: KEY_W]), M_TDATA_W'(want.entry));
    if (last !== want.last)
      report_mismatch("tlast", M_TDATA_W'(last), M_TDATA_W'(want.last));
    if (data[M_TDATA_W-1:M_FIELDS_W] !== '0)
      report_mismatch("zero fill", M_TDATA_W'(data[M_TDATA_W-1:M_FIELDS_W]), '0);
  endtask

  // Watch both channels; predict before checking so a same-edge beat finds its entry
  always @(posedge clk) begin
    if (rst) begin
      queue_image.delete();
      expected_beats.delete();
    end else begin
      if (s_tvalid && s_tready) predict_item(s_tdata[OP_W-1:0], s_tdata[OP_W +: KEY_W]);
      if (m_tvalid && m_tready) check_beat(m_tdata, m_tlast);
    end
    pending    <= expected_beats.size();
    fail_count <= failures;
  end

endmodule

@@ bench/tb.sv @@
module tb;
  import oqrk_pkg::*;

  localparam int      DEPTH        = 16;
  localparam opcode_t OP_UNUSED    = 2'd3;
  localparam int      RANDOM_ITEMS = 255;
  localparam int      SETTLE_TICKS = DEPTH + 24;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic                 m_tready = 1'b0;
  logic                 s_tready;
  logic                 m_tvalid;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tlast;

  int   fail_count;
  int   pending;
  bit   idle_on = 1'b1;
  key_t key_pool[6];

  initial begin
    forever #6 clk = ~clk;
  end

  ordered_queue_remove_by_key #(.DEPTH(DEPTH)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  oqrk_checker #(.DEPTH(DEPTH)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Mostly short gaps, now and then a long one; none in calm stretches
  function automatic int pick_gap();
    if (!idle_on) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(0, 3);
  endfunction

  function automatic key_t pick_key();
    if ($urandom_range(0, 4) == 0) return key_t'($urandom);
    return key_pool[$urandom_range(0, 5)];
  endfunction

  // Fill phases lean on push, drain phases on remove, the rest mix everything
  function automatic opcode_t pick_op(int kind);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return OP_UNUSED;
    case (kind)
      0:       return (roll < 85) ? OP_PUSH : (roll < 93) ? OP_REMOVE : OP_READ;
      1:       return (roll < 80) ? OP_REMOVE : (roll < 90) ? OP_PUSH : OP_READ;
      default: return (roll < 45) ? OP_PUSH : (roll < 85) ? OP_REMOVE : OP_READ;
    endcase
  endfunction

  // Present one beat, hold it until taken, then maybe idle
  task automatic send_item(opcode_t op, key_t key);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_TDATA_W - S_FIELDS_W){1'b0}}, key, op};
    do @(posedge clk); while (!s_tready);
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the input channel until every expected beat has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Output back-pressure
  initial begin : ready_driver
    int stall;
    int run_len;
    @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      run_len = $urandom_range(1, 6);
      repeat (run_len) @(posedge clk);
    end
  end

  initial begin : stimulus
    int      sent;
    int      kind;
    int      phase_len;
    opcode_t op;
    key_t    key;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    key_pool[4] = key_t'($urandom);
    key_pool[5] = key_t'($urandom);
    sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty queue, extreme keys, duplicates, head and tail removal
    send_item(OP_READ,   32'h0000_0000);
    send_item(OP_REMOVE, 32'h1234_5678);
    send_item(OP_PUSH,   32'h8000_0000);
    send_item(OP_PUSH,   32'h7FFF_FFFF);
    send_item(OP_PUSH,   32'h0000_0000);
    send_item(OP_PUSH,   32'hFFFF_FFFF);
    send_item(OP_PUSH,   32'h7FFF_FFFF);
    send_item(OP_READ,   32'hFFFF_FFFF);
    send_item(OP_REMOVE, 32'h7FFF_FFFF);
    send_item(OP_READ,   32'h0000_0000);
    send_item(OP_REMOVE, 32'h5555_AAAA);
    send_item(OP_UNUSED, 32'hFFFF_FFFF);
    send_item(OP_REMOVE, 32'h8000_0000);
    send_item(OP_REMOVE, 32'h7FFF_FFFF);
    send_item(OP_READ,   32'h0000_0000);
    wait_drained();

    // Random phases, each closed by a readout of the whole queue
    while (sent < RANDOM_ITEMS) begin
      kind      = $urandom_range(0, 2);
      idle_on   = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(8, 30);
      for (int i = 0; i < phase_len; i++) begin
        op  = pick_op(kind);
        key = (op == OP_UNUSED || $urandom_range(0, 9) == 0) ? key_t'($urandom) : pick_key();
        send_item(op, key);
        if (op != OP_UNUSED) sent++;
      end
      send_item(OP_READ, key_t'($urandom));
      sent++;
      if ($urandom_range(0, 2) == 0) wait_drained();
    end

    idle_on = 1'b1;
    wait_drained();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #12_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ ordered_queue_remove_by_key.f @@
design/oqrk_pkg.sv
design/oqrk_ram.sv
design/ordered_queue_remove_by_key.sv
bench/oqrk_checker.sv
bench/tb.sv
